// ===== src/cctx_pkg.sv =====
// Shared types and constants for the periodic CAN transmit table.
// Used by the command front end, the table engine and the top level.
package cctx_pkg;

  localparam int unsigned IdW    = 29;
  localparam int unsigned DataW  = 64;
  localparam int unsigned LenW   = 4;
  localparam int unsigned IvlW   = 16;
  localparam int unsigned TicksW = 13;
  localparam int unsigned MaxResults = 16;
  localparam logic [TicksW-1:0] TicksMax = {TicksW{1'b1}};
  localparam logic [LenW-1:0] LenMax = LenW'(8);

  typedef enum logic [1:0] {
    CMD_SEND = 2'd0,
    CMD_SET  = 2'd1,
    CMD_TICK = 2'd2
  } cmd_e;

  // One classified command as passed from front end to table engine.
  typedef struct packed {
    cmd_e              cmd;
    logic              ext;
    logic [IdW-1:0]    id;
    logic [DataW-1:0]  data;
    logic [LenW-1:0]   len;
    logic [IvlW-1:0]   ivl;
  } cmd_t;

  // One frame leaving the block.
  typedef struct packed {
    logic              ext;
    logic [IdW-1:0]    id;
    logic [DataW-1:0]  data;
    logic [LenW-1:0]   len;
    logic              last;
  } frame_t;

  // Clear payload bytes at or above the length.
  function automatic logic [DataW-1:0] keep_bytes(logic [DataW-1:0] d, logic [LenW-1:0] l);
    logic [DataW-1:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (LenW'(b) < l) m[b*8 +: 8] = 8'hFF;
    end
    return d & m;
  endfunction

endpackage

// ===== src/cctx_front.sv =====
// Front end: accepts input items, saturates length, masks payload, classifies
// the command and holds it in a two-entry queue. Depends on cctx_pkg.
module cctx_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              command_i,
  input  logic              ext_i,
  input  logic [28:0]       id_i,
  input  logic [63:0]       data_i,
  input  logic [3:0]        len_i,
  input  logic [15:0]       ivl_i,
  output logic              q_valid_o,
  input  logic              q_ready_i,
  output cctx_pkg::cmd_t    q_cmd_o
);

  cctx_pkg::cmd_t slot_q [2];
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q;
  cctx_pkg::cmd_t cls;
  logic [3:0]     len_sat;
  logic           push, pop;

  // Classify and clean up the incoming item.
  always_comb begin
    len_sat = (len_i > cctx_pkg::LenMax) ? cctx_pkg::LenMax : len_i;
    cls.ext  = ext_i;
    cls.id   = id_i;
    cls.len  = len_sat;
    cls.data = cctx_pkg::keep_bytes(data_i, len_sat);
    cls.ivl  = ivl_i;
    if (command_i)         cls.cmd = cctx_pkg::CMD_TICK;
    else if (ivl_i == '0)  cls.cmd = cctx_pkg::CMD_SEND;
    else                   cls.cmd = cctx_pkg::CMD_SET;
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_cmd_o    = slot_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_q] <= cls;
  end

  // Queue pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push) else $error("push into full queue");
  a_ptr_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> wr_q == rd_q) else $error("pointer mismatch");

endmodule

// ===== src/cctx_engine.sv =====
// Table engine: holds the periodic table, scans one entry per cycle per command
// (a tick can stall), emits frames via an output register. Depends on cctx_pkg.
module cctx_engine #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  output logic              q_ready_o,
  input  cctx_pkg::cmd_t    q_cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cctx_pkg::frame_t  out_frame_o
);

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned NW   = $clog2(cctx_pkg::MaxResults + 1);
  localparam int unsigned FrameW = $bits(cctx_pkg::frame_t);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_FREE = 5'b00100,
    S_EMIT = 5'b01000,
    S_FLSH = 5'b10000
  } state_e;

  state_e state_q;

  logic [TABLE_ENTRIES-1:0] valid_q;
  logic                     ext_m  [TABLE_ENTRIES];
  logic [28:0]              id_m   [TABLE_ENTRIES];
  logic [63:0]              data_m [TABLE_ENTRIES];
  logic [3:0]               len_m  [TABLE_ENTRIES];
  logic [15:0]              ivl_m  [TABLE_ENTRIES];
  logic [12:0]              tick_m [TABLE_ENTRIES];

  cctx_pkg::cmd_t   cmd_q;
  logic [CntW-1:0]  pos_q;
  logic             free_hit_q;
  logic [IdxW-1:0]  free_q;
  logic [NW-1:0]    n_q;
  // Pending due frame held until the next one is known, to mark the last.
  logic             pend_q;
  cctx_pkg::frame_t pend_frame_q;
  logic             ov_q;
  cctx_pkg::frame_t ov_frame_q;

  logic [IdxW-1:0]  idx;
  logic             hit, due;
  logic [12:0]      t_inc;
  logic [16:0]      t_x10;
  logic             can_load;
  logic             is_tick, tick_live, take, scan_stall;
  logic             ov_load;

  assign idx   = pos_q[IdxW-1:0];
  assign hit   = valid_q[idx] && (id_m[idx] == cmd_q.id);
  assign t_inc = (tick_m[idx] < cctx_pkg::TicksMax) ? tick_m[idx] + 13'd1 : tick_m[idx];
  assign t_x10 = {1'b0, t_inc, 3'b000} + {3'b000, t_inc, 1'b0};
  assign due   = {1'b0, t_x10} >= {2'b00, ivl_m[idx]};

  assign out_valid_o = ov_q;
  assign out_frame_o = ov_frame_q;
  assign q_ready_o   = (state_q == S_IDLE);

  assign can_load   = !ov_q || out_ready_i;
  assign is_tick    = (cmd_q.cmd == cctx_pkg::CMD_TICK);
  assign tick_live  = valid_q[idx] && (ivl_m[idx] != '0);
  assign take       = tick_live && due && (n_q < NW'(cctx_pkg::MaxResults));
  // A pending frame blocks the scan until the output register frees.
  assign scan_stall = pend_q && take && !can_load;

  // A new frame enters the output register in these cases.
  always_comb begin
    ov_load = 1'b0;
    case (state_q)
      S_SCAN:  ov_load = is_tick && !scan_stall && take && pend_q;
      S_FREE:  ov_load = can_load;
      S_EMIT:  ov_load = can_load && (cmd_q.cmd == cctx_pkg::CMD_SEND
                                      || free_hit_q || !valid_q[idx]);
      S_FLSH:  ov_load = pend_q && can_load;
      default: ov_load = 1'b0;
    endcase
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (ov_load) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  // Main sequencer: one entry per cycle unless stalled, results via the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      pend_q <= 1'b0;
      pos_q <= '0;
      free_hit_q <= 1'b0;
      n_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            state_q <= S_SCAN;
            pos_q <= '0;
            free_hit_q <= 1'b0;
            n_q <= '0;
            pend_q <= 1'b0;
          end
        end
        S_SCAN: begin
          if (is_tick) begin
            if (!scan_stall) begin
              if (take) begin
                n_q <= n_q + NW'(1);
                pend_q <= 1'b1;
              end
              if (pos_q == CntW'(TABLE_ENTRIES - 1)) begin
                state_q <= S_FLSH;
              end else begin
                pos_q <= pos_q + CntW'(1);
              end
            end
          end else begin
            if (!valid_q[idx] && !free_hit_q) free_hit_q <= 1'b1;
            if (hit) begin
              state_q <= S_FREE;
            end else if (pos_q == CntW'(TABLE_ENTRIES - 1)) begin
              state_q <= S_EMIT;
            end else begin
              pos_q <= pos_q + CntW'(1);
            end
          end
        end
        S_FREE: begin
          // Match found: drop or refresh, then send.
          if (can_load) begin
            if (cmd_q.cmd == cctx_pkg::CMD_SEND) valid_q[idx] <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (can_load) begin
            if (cmd_q.cmd != cctx_pkg::CMD_SEND && (free_hit_q || !valid_q[idx])) begin
              valid_q[(free_hit_q) ? free_q : idx] <= 1'b1;
            end
            state_q <= S_IDLE;
          end
        end
        S_FLSH: begin
          if (!pend_q) begin
            state_q <= S_IDLE;
          end else if (can_load) begin
            pend_q <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Payload registers: command, free slot, output frame and table fields.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && q_valid_i) cmd_q <= q_cmd_i;
    if (state_q == S_SCAN && !is_tick && !valid_q[idx] && !free_hit_q) free_q <= idx;
    case (state_q)
      S_SCAN: begin
        if (is_tick && tick_live && !scan_stall) begin
          if (take) begin
            tick_m[idx] <= '0;
            pend_frame_q.ext  <= ext_m[idx];
            pend_frame_q.id   <= ext_m[idx] ? id_m[idx] : {13'd0, id_m[idx][15:0]};
            pend_frame_q.data <= data_m[idx];
            pend_frame_q.len  <= len_m[idx];
            pend_frame_q.last <= 1'b0;
            if (pend_q) ov_frame_q <= pend_frame_q;
          end else begin
            tick_m[idx] <= t_inc;
          end
        end
      end
      S_FREE, S_EMIT: begin
        if (can_load) begin
          ov_frame_q.ext  <= cmd_q.ext;
          ov_frame_q.id   <= cmd_q.ext ? cmd_q.id : {13'd0, cmd_q.id[15:0]};
          ov_frame_q.data <= cmd_q.data;
          ov_frame_q.len  <= cmd_q.len;
          ov_frame_q.last <= 1'b1;
          if (cmd_q.cmd == cctx_pkg::CMD_SET) begin
            if (state_q == S_FREE) begin
              data_m[idx] <= cmd_q.data;
              len_m[idx]  <= cmd_q.len;
              ivl_m[idx]  <= cmd_q.ivl;
              tick_m[idx] <= '0;
            end else if (free_hit_q || !valid_q[idx]) begin
              ext_m[(free_hit_q) ? free_q : idx]  <= cmd_q.ext;
              id_m[(free_hit_q) ? free_q : idx]   <= cmd_q.id;
              data_m[(free_hit_q) ? free_q : idx] <= cmd_q.data;
              len_m[(free_hit_q) ? free_q : idx]  <= cmd_q.len;
              ivl_m[(free_hit_q) ? free_q : idx]  <= cmd_q.ivl;
              tick_m[(free_hit_q) ? free_q : idx] <= '0;
            end
          end
        end
      end
      S_FLSH: begin
        // The held frame is the final one of the tick.
        if (pend_q && can_load) begin
          ov_frame_q <= {pend_frame_q[FrameW-1:1], 1'b1};
        end
      end
      default: ;
    endcase
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_ready_o |-> !pend_q || state_q != S_IDLE) else $error("pending frame lost");
  a_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NW'(cctx_pkg::MaxResults)) else $error("too many frames per tick");

endmodule

// ===== src/can_cyclic_tx_scheduler.sv =====
// Periodic CAN transmit table, top level.
// Channel s_axis carries commands (set/send frame, or a 10 ms tick).
// Channel m_axis carries frames; tlast marks the final frame of one command.
// A set or send command scans the table one entry per cycle until a match or
// the end. A tick scans every entry the same way (pausing while the output
// is busy) and sends each due entry in index order, at most 16 frames per tick.
// The front end holds up to two commands in a queue, so input keeps being
// accepted while the engine works or while a frame waits in the output
// register. A stalled receiver halts the scan, nothing is dropped.
// Reset clears all valid flags; the table starts empty and no clearing
// pass is needed.
// Depends on cctx_pkg, cctx_front and cctx_engine.
module can_cyclic_tx_scheduler #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: extended_id[0], msg_id[29:1], payload[93:30], payload_length[97:94],
  // interval_ms[113:98], zero fill up to 120
  input  logic [119:0] s_axis_tdata,
  // tuser: command
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: frame_extended[0], frame_id[29:1], frame_data[93:30],
  // frame_length[97:94], zero fill up to 104
  output logic [103:0] m_axis_tdata,
  // tlast: last_in_run
  output logic         m_axis_tlast
);

  logic             q_valid, q_ready;
  cctx_pkg::cmd_t   q_cmd;
  cctx_pkg::frame_t fr;

  cctx_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .command_i  (s_axis_tuser),
    .ext_i      (s_axis_tdata[0]),
    .id_i       (s_axis_tdata[29:1]),
    .data_i     (s_axis_tdata[93:30]),
    .len_i      (s_axis_tdata[97:94]),
    .ivl_i      (s_axis_tdata[113:98]),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_cmd_o    (q_cmd)
  );

  cctx_engine #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_engine (
    .clk_i, .rst_ni,
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_cmd_i     (q_cmd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_frame_o (fr)
  );

  assign m_axis_tdata = {6'd0, fr.len, fr.data, fr.id, fr.ext};
  assign m_axis_tlast = fr.last;

endmodule
